// ===== src/dau_pkg.sv =====
// dau_pkg: shared types, constants and helper functions of the dihedral angle unit
// no dependencies
package dau_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int CORDIC_MAX       = 40;
  localparam int SQ_STEPS         = 21;   // root bits of a 42 bit m.m
  localparam int CW               = 44;   // cordic x/y width
  localparam int ZW               = 35;   // cordic angle width, 2^-24 degree
  localparam int AW               = 90;   // s/c width before normalizing

  localparam logic signed [ZW-1:0] DEG90_Q24  = 35'sd1509949440;
  localparam logic signed [26:0]   DEG180_Q16 = 27'sd11796480;

  localparam logic [1:0] REG_BOX_X = 2'd0;
  localparam logic [1:0] REG_BOX_Y = 2'd1;
  localparam logic [1:0] REG_BOX_Z = 2'd2;

  localparam logic [30:0] ATAN_TAB [CORDIC_MAX] = '{
    31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938, 31'd60000934,
    31'd30029717, 31'd15018523, 31'd7509720, 31'd3754917, 31'd1877466,
    31'd938734, 31'd469367, 31'd234684, 31'd117342, 31'd58671, 31'd29335,
    31'd14668, 31'd7334, 31'd3667, 31'd1833, 31'd917, 31'd458, 31'd229,
    31'd115, 31'd57, 31'd29, 31'd14, 31'd7, 31'd4, 31'd2, 31'd1, 31'd0,
    31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0
  };

  typedef struct packed {
    logic [41:0] n;
    logic [43:0] r;
  } sq_t;

  typedef struct packed {
    logic                 valid;
    logic                 deg;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic               valid;
    logic               deg;
    logic signed [65:0] dab3;
    logic signed [87:0] c;
  } pay_t;

  // single minimum image correction
  function automatic logic signed [35:0] wrap(input logic signed [35:0] d,
                                              input logic [30:0] len);
    logic [35:0] mag;
    logic [36:0] twice;
    logic signed [35:0] l36;
    mag   = d[35] ? 36'(-d) : 36'(d);
    twice = {mag, 1'b0};
    l36   = $signed({5'b0, len});
    if (len != '0 && twice > {6'b0, len}) begin
      return d[35] ? d + l36 : d - l36;
    end
    return d;
  endfunction

  function automatic logic [35:0] mag36(input logic signed [35:0] v);
    return v[35] ? ~v : v;
  endfunction

  // shift that brings every component into 21 signed bits
  function automatic logic [3:0] vshift(input logic [35:0] u);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 36; i++) begin
      if (u[i]) p = 6'(i);
    end
    return (p >= 6'd20) ? 4'(p - 6'd19) : 4'd0;
  endfunction

  function automatic logic [AW-1:0] magw(input logic signed [AW-1:0] v);
    return v[AW-1] ? ~v : v;
  endfunction

  // shift that brings s and c into [-2^40, 2^40)
  function automatic logic [6:0] nshift(input logic [AW-1:0] u);
    logic [6:0] p;
    p = '0;
    for (int i = 0; i < AW; i++) begin
      if (u[i]) p = 7'(i);
    end
    return (p >= 7'd40) ? 7'(p - 7'd39) : 7'd0;
  endfunction

endpackage

// ===== src/dau_if.sv =====
// dau_if: handshake channels of the dihedral angle unit
// depends on nothing
interface dau_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
  logic signed [31:0] p3_x, p3_y, p3_z, p4_x, p4_y, p4_z;
  modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                  p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, input ready);
  modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, output ready);
endinterface

interface dau_res_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] angle_deg;
  logic               degenerate;
  modport source (output valid, angle_deg, degenerate, input ready);
  modport sink (input valid, angle_deg, degenerate, output ready);
endinterface

interface dau_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/dau_sqrt_cell.sv =====
// dau_sqrt_cell: one bit pair of the pipelined integer square root
// depends on dau_pkg
module dau_sqrt_cell #(
  parameter int J = 0
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  dau_pkg::sq_t in_i,
  output dau_pkg::sq_t out_o
);
  localparam logic [43:0] Bit = 44'(1) << (2 * J);

  logic [43:0]  trial;
  dau_pkg::sq_t out_d, out_q;

  always_comb begin
    trial = in_i.r + Bit;
    out_d = in_i;
    if ({2'b0, in_i.n} >= trial) begin
      out_d.n = in_i.n - trial[41:0];
      out_d.r = (in_i.r >> 1) + Bit;
    end else begin
      out_d.r = in_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_q <= out_d;
  end

  assign out_o = out_q;
endmodule

// ===== src/dau_cordic_cell.sv =====
// dau_cordic_cell: one vectoring cordic micro-rotation
// depends on dau_pkg
module dau_cordic_cell #(
  parameter int I = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  dau_pkg::cord_t in_i,
  output dau_pkg::cord_t out_o
);
  localparam logic signed [dau_pkg::ZW-1:0] Atan =
    $signed({4'b0, dau_pkg::ATAN_TAB[I]});

  logic signed [dau_pkg::CW-1:0] xs, ys;
  dau_pkg::cord_t out_d, out_q;

  always_comb begin
    xs    = in_i.x >>> I;
    ys    = in_i.y >>> I;
    out_d = in_i;
    if (!in_i.y[dau_pkg::CW-1]) begin
      out_d.x = in_i.x + ys;
      out_d.y = in_i.y - xs;
      out_d.z = in_i.z + Atan;
    end else begin
      out_d.x = in_i.x - ys;
      out_d.y = in_i.y + xs;
      out_d.z = in_i.z - Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;
endmodule

// ===== src/dihedral_angle_unit.sv =====
// dihedral_angle_unit: pipelined torsion angle of four atoms, one word per cycle
// while not stalled; the 21 cell square root chain and the cordic cell row set
// the depth
// the whole pipeline advances while the output register is empty or being taken
// reset clears the valid bits, the delay line, the cordic row and the box lengths
// depends on dau_pkg, dau_if, dau_sqrt_cell, dau_cordic_cell
module dihedral_angle_unit #(
  parameter int CORDIC_STEPS = dau_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  dau_pt_if.sink    pt_i,
  dau_res_if.source res_o,
  dau_cfg_if.sink   cfg_i
);
  localparam int SQ = dau_pkg::SQ_STEPS;
  localparam int ND = SQ - 2;   // payload delay to meet the root
  localparam int NC = CORDIC_STEPS;

  logic en;
  logic [30:0] box_q [3];

  // config registers, always ready
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q[0] <= '0;
      box_q[1] <= '0;
      box_q[2] <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        dau_pkg::REG_BOX_X: box_q[0] <= cfg_i.data[30:0];
        dau_pkg::REG_BOX_Y: box_q[1] <= cfg_i.data[30:0];
        dau_pkg::REG_BOX_Z: box_q[2] <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  // global stall: advance when output register is free
  assign en         = !res_o.valid || res_o.ready;
  assign pt_i.ready = en;

  // valid bits of the front stages
  logic [5:1] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[4:1], pt_i.valid};
    end
  end

  // stage 1: bond differences and first wrap
  logic signed [31:0] p [12];
  logic signed [35:0] b1_q [3], mid_q [3], b3_q [3];
  assign p = '{pt_i.p1_x, pt_i.p1_y, pt_i.p1_z, pt_i.p2_x, pt_i.p2_y, pt_i.p2_z,
               pt_i.p3_x, pt_i.p3_y, pt_i.p3_z, pt_i.p4_x, pt_i.p4_y, pt_i.p4_z};

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        b1_q[k]  <= dau_pkg::wrap(36'(p[k]) - 36'(p[3+k]), box_q[k]);
        mid_q[k] <= dau_pkg::wrap(36'(p[6+k]) - 36'(p[3+k]), box_q[k]);
        b3_q[k]  <= dau_pkg::wrap(36'(p[9+k]) - 36'(p[6+k]), box_q[k]);
      end
    end
  end

  // stage 2: negated middle bond, wrapped again
  logic signed [35:0] b1b_q [3], m_q [3], b3b_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        b1b_q[k] <= b1_q[k];
        m_q[k]   <= dau_pkg::wrap(-mid_q[k], box_q[k]);
        b3b_q[k] <= b3_q[k];
      end
    end
  end

  // stage 3: block scaling of each vector into 21 bits
  logic [3:0] sh1, shm, sh3;
  logic signed [20:0] b1s_q [3], ms_q [3], b3s_q [3];
  always_comb begin
    sh1 = dau_pkg::vshift(dau_pkg::mag36(b1b_q[0]) | dau_pkg::mag36(b1b_q[1]) |
                          dau_pkg::mag36(b1b_q[2]));
    shm = dau_pkg::vshift(dau_pkg::mag36(m_q[0]) | dau_pkg::mag36(m_q[1]) |
                          dau_pkg::mag36(m_q[2]));
    sh3 = dau_pkg::vshift(dau_pkg::mag36(b3b_q[0]) | dau_pkg::mag36(b3b_q[1]) |
                          dau_pkg::mag36(b3b_q[2]));
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        b1s_q[k] <= 21'(b1b_q[k] >>> sh1);
        ms_q[k]  <= 21'(m_q[k] >>> shm);
        b3s_q[k] <= 21'(b3b_q[k] >>> sh3);
      end
    end
  end

  // stage 4: cross products and m.m
  logic signed [42:0] a_q [3], b_q [3];
  logic signed [20:0] b3c_q [3];
  logic        [41:0] mm_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q[0] <= 43'(b1s_q[1] * ms_q[2]) - 43'(b1s_q[2] * ms_q[1]);
      a_q[1] <= 43'(b1s_q[2] * ms_q[0]) - 43'(b1s_q[0] * ms_q[2]);
      a_q[2] <= 43'(b1s_q[0] * ms_q[1]) - 43'(b1s_q[1] * ms_q[0]);
      b_q[0] <= 43'(b3s_q[1] * ms_q[2]) - 43'(b3s_q[2] * ms_q[1]);
      b_q[1] <= 43'(b3s_q[2] * ms_q[0]) - 43'(b3s_q[0] * ms_q[2]);
      b_q[2] <= 43'(b3s_q[0] * ms_q[1]) - 43'(b3s_q[1] * ms_q[0]);
      b3c_q  <= b3s_q;
      mm_q   <= 42'(ms_q[0] * ms_q[0]) + 42'(ms_q[1] * ms_q[1]) +
                42'(ms_q[2] * ms_q[2]);
    end
  end

  // stage 5: partial products of a.b3 and a.b, b split to keep multipliers narrow
  logic signed [63:0] pab3_q [3];
  logic signed [65:0] plo_q [3];
  logic signed [63:0] phi_q [3];
  logic               deg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pab3_q[k] <= 64'(a_q[k] * b3c_q[k]);
        plo_q[k]  <= 66'(a_q[k] * $signed({1'b0, b_q[k][21:0]}));
        phi_q[k]  <= 64'(a_q[k] * $signed(b_q[k][42:22]));
      end
      deg_q <= (a_q[0] == '0 && a_q[1] == '0 && a_q[2] == '0) ||
               (b_q[0] == '0 && b_q[1] == '0 && b_q[2] == '0);
    end
  end

  // stage 6: sums, then delay line to meet the square root
  dau_pkg::pay_t pay_d;
  dau_pkg::pay_t dly_q [ND+1];
  always_comb begin
    pay_d.valid = v_q[5];
    pay_d.deg   = deg_q;
    pay_d.dab3  = 66'(pab3_q[0]) + 66'(pab3_q[1]) + 66'(pab3_q[2]);
    pay_d.c     = '0;
    for (int k = 0; k < 3; k++) begin
      pay_d.c = pay_d.c + (88'(phi_q[k]) <<< 22) + 88'(plo_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= ND; i++) dly_q[i] <= '0;
    end else if (en) begin
      dly_q[0] <= pay_d;
      for (int i = 1; i <= ND; i++) dly_q[i] <= dly_q[i-1];
    end
  end

  // square root chain, one result bit per cell, fed from stage 4
  dau_pkg::sq_t sq [SQ+1];
  assign sq[0].n = mm_q;
  assign sq[0].r = '0;
  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    dau_sqrt_cell #(.J(SQ - 1 - g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .in_i  (sq[g]),
      .out_o (sq[g+1])
    );
  end

  // s partial products: root times both halves of a.b3
  logic signed [21:0] rg;
  logic signed [55:0] slo_q;
  logic signed [54:0] shi_q;
  logic signed [87:0] ca_q;
  logic               va_q, dga_q;
  assign rg = $signed({1'b0, sq[SQ].r[20:0]});
  always_ff @(posedge clk_i) begin
    if (en) begin
      slo_q <= 56'(rg * $signed({1'b0, dly_q[ND].dab3[32:0]}));
      shi_q <= 55'(rg * $signed(dly_q[ND].dab3[65:33]));
      ca_q  <= dly_q[ND].c;
      dga_q <= dly_q[ND].deg;
    end
  end

  // s assembled
  logic signed [dau_pkg::AW-1:0] sb_q, cb_q;
  logic                          dgb_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q  <= (dau_pkg::AW'(shi_q) <<< 33) + dau_pkg::AW'(slo_q);
      cb_q  <= dau_pkg::AW'(ca_q);
      dgb_q <= dga_q;
    end
  end

  // common shift for s and c
  logic signed [dau_pkg::AW-1:0] sn_q, cn_q;
  logic [6:0]                    nsh_q;
  logic                          dgn_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      nsh_q <= dau_pkg::nshift(dau_pkg::magw(sb_q) | dau_pkg::magw(cb_q));
      sn_q  <= sb_q;
      cn_q  <= cb_q;
      dgn_q <= dgb_q;
    end
  end

  logic vb_q, vn_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vn_q <= 1'b0;
    end else if (en) begin
      va_q <= dly_q[ND].valid;
      vb_q <= va_q;
      vn_q <= vb_q;
    end
  end

  // shift and left half plane pre-rotation into the cordic row
  logic signed [dau_pkg::CW-1:0] xs, ys;
  dau_pkg::cord_t c0_d, c0_q;
  always_comb begin
    xs         = dau_pkg::CW'(cn_q >>> nsh_q);
    ys         = dau_pkg::CW'(sn_q >>> nsh_q);
    c0_d.valid = vn_q;
    c0_d.deg   = dgn_q;
    c0_d.x     = xs;
    c0_d.y     = ys;
    c0_d.z     = '0;
    if (xs[dau_pkg::CW-1]) begin
      if (!ys[dau_pkg::CW-1]) begin
        // toward +90, so s zero with c negative lands on +180
        c0_d.x = ys;
        c0_d.y = -xs;
        c0_d.z = dau_pkg::DEG90_Q24;
      end else begin
        c0_d.x = -ys;
        c0_d.y = xs;
        c0_d.z = -dau_pkg::DEG90_Q24;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
    end else if (en) begin
      c0_q <= c0_d;
    end
  end

  // cordic row, each cell hands x, y, z to its neighbor every cycle the pipeline advances
  dau_pkg::cord_t cr [NC+1];
  assign cr[0] = c0_q;
  for (genvar g = 0; g < NC; g++) begin : g_cordic
    dau_cordic_cell #(.I(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .in_i   (cr[g]),
      .out_o  (cr[g+1])
    );
  end

  // round half up to Q16, saturate, output register
  logic signed [26:0] ang;
  logic signed [24:0] ang_q;
  logic               deg_out_q, res_valid_q;
  always_comb begin
    ang = 27'((cr[NC].z + dau_pkg::ZW'(128)) >>> 8);
    if (ang > dau_pkg::DEG180_Q16) ang = dau_pkg::DEG180_Q16;
    if (ang < -dau_pkg::DEG180_Q16) ang = -dau_pkg::DEG180_Q16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en) begin
      res_valid_q <= cr[NC].valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q     <= cr[NC].deg ? '0 : ang[24:0];
      deg_out_q <= cr[NC].deg;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.angle_deg  = ang_q;
  assign res_o.degenerate = deg_out_q;
endmodule
